/* hw/rtl/mipbox_pkg.sv */
// Shared constants and register codes for the 2x2 box mipmap downscaler.
package mipbox_pkg;

   // Widest source row the line buffer holds, and tallest source level.
   localparam int MAX_WIDTH    = 4096;
   localparam int HEIGHT_LIMIT = 4096;

   localparam int CHAN_W  = 16;                    // one color channel
   localparam int PIX_W   = 4 * CHAN_W;            // packed RGBA word
   localparam int SUM_W   = CHAN_W + 2;            // sum of up to four channels
   localparam int CFG_W   = 13;                    // size register width
   localparam int CSR_IDX_W = 4;
   localparam int COORD_W = 11;                    // next-level column and row

   localparam int COL_W   = $clog2(MAX_WIDTH);
   localparam int ROW_W   = $clog2(HEIGHT_LIMIT);
   localparam int HALF_DEPTH = MAX_WIDTH / 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH  = 4'd0,
      CSR_IMAGE_HEIGHT = 4'd1
   } csr_index_type;

endpackage

/* hw/rtl/mipbox_if.sv */
// Channel interfaces: source pixel words, result words and register writes.
interface mipbox_pix_if
   import mipbox_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [CHAN_W-1:0] in_red;
   logic [CHAN_W-1:0] in_green;
   logic [CHAN_W-1:0] in_blue;
   logic [CHAN_W-1:0] in_alpha;

   modport source (output valid, in_red, in_green, in_blue, in_alpha, input ready);
   modport sink (input valid, in_red, in_green, in_blue, in_alpha, output ready);
endinterface

interface mipbox_out_if
   import mipbox_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [CHAN_W-1:0]  out_red;
   logic [CHAN_W-1:0]  out_green;
   logic [CHAN_W-1:0]  out_blue;
   logic [CHAN_W-1:0]  out_alpha;
   logic [COORD_W-1:0] out_column;
   logic [COORD_W-1:0] out_row;
   logic               frame_done;

   modport source (output valid, out_red, out_green, out_blue, out_alpha,
                   out_column, out_row, frame_done, input ready);
   modport sink (input valid, out_red, out_green, out_blue, out_alpha,
                 out_column, out_row, frame_done, output ready);
endinterface

interface mipbox_csr_if
   import mipbox_pkg::*;
   ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CFG_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

/* hw/rtl/mipbox_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module mipbox_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/mipmap_box_2x2_downscale_top.sv */
// Top level of the 2x2 box-filter mipmap downscaler.
// Usage:
//   req_chan  takes one RGBA word per source pixel, in raster order.
//   rsp_chan  gives one next-level word when the last pixel of a 2x2 block
//             arrives: each channel is the block sum shifted right by two,
//             with column and row in the next level and frame_done on the
//             last word of the level. Blocks cut by an odd right or bottom
//             border sum only two or one pixels and are still divided by 4.
//   csr_chan  writes image_width (index 0) and image_height (index 1), always
//             ready; write it with no pixel in flight, it applies from the next pixel.
// Path: the pixel that completes a block is registered in the read stage, and
//   its word in the output register that drives rsp_chan.
// Throughput: one pixel per cycle while rsp_chan takes its words. The even
//   source row sits in two line-buffer RAMs (even and odd columns) with one
//   write and one read port each, so the four-pixel sum reads both halves in the same cycle.
// Reset: counters clear, sizes go to 4096 x 4096, pipeline empties. The line
//   buffers are not cleared; every read follows a write in the same level.
// Stall: when rsp_chan is not ready the output register holds its word, one
//   more word waits in the read stage, and req_chan drops ready only when
//   both are full.
module mipmap_box_2x2_downscale_top
   import mipbox_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   mipbox_pix_if.sink   req_chan,
   mipbox_out_if.source rsp_chan,
   mipbox_csr_if.sink   csr_chan
);

   typedef enum logic [1:0] {
      SUM_PIX,         // lone pixel: odd width and odd height corner
      SUM_HELD_PIX,    // held pixel plus current: odd-height bottom row
      SUM_LINE_PIX,    // line buffer plus current: odd-width right column
      SUM_FOUR         // full 2x2 block
   } sum_mode_type;

   // Size registers, kept as the index of the last column and row.
   logic [COL_W-1:0] width_last_ff, width_last_in;
   logic [ROW_W-1:0] height_last_ff, height_last_in;

   logic [COL_W-1:0] col_cnt_ff, col_cnt_in;
   logic [ROW_W-1:0] row_cnt_ff, row_cnt_in;
   logic [PIX_W-1:0] held_ff;

   // Read stage
   logic               s1_valid_ff, s1_valid_in;
   sum_mode_type       s1_mode_ff;
   logic [PIX_W-1:0]   s1_pix_ff;
   logic [PIX_W-1:0]   s1_held_ff;
   logic [COORD_W-1:0] s1_col_ff;
   logic [COORD_W-1:0] s1_row_ff;
   logic               s1_done_ff;

   // Output register
   logic               out_valid_ff, out_valid_in;
   logic [PIX_W-1:0]   out_pix_ff, out_pix_in;
   logic [COORD_W-1:0] out_col_ff;
   logic [COORD_W-1:0] out_row_ff;
   logic               out_done_ff;

   logic             accept;
   logic             s1_advance;
   logic [COL_W-1:0] col;
   logic [ROW_W-1:0] row;
   logic             last_col, last_row, done, col_odd, row_odd;
   logic             emit;
   sum_mode_type     mode;
   logic [PIX_W-1:0] pix;
   logic [PIX_W-1:0] even_rd, odd_rd;

   // ---------------------------------------------------------------- config
   assign csr_chan.ready = 1'b1;

   always_comb begin
      width_last_in  = width_last_ff;
      height_last_in = height_last_ff;
      if (csr_chan.valid) begin
         case (csr_chan.index)
            CSR_IMAGE_WIDTH: begin
               // Zero reads as one, oversize saturates to the buffer limit.
               if (csr_chan.data == '0) begin
                  width_last_in = '0;
               end else if (32'(csr_chan.data) > MAX_WIDTH) begin
                  width_last_in = COL_W'(MAX_WIDTH - 1);
               end else begin
                  width_last_in = COL_W'(csr_chan.data - CFG_W'(1));
               end
            end
            CSR_IMAGE_HEIGHT: begin
               if (csr_chan.data == '0) begin
                  height_last_in = '0;
               end else if (32'(csr_chan.data) > HEIGHT_LIMIT) begin
                  height_last_in = ROW_W'(HEIGHT_LIMIT - 1);
               end else begin
                  height_last_in = ROW_W'(csr_chan.data - CFG_W'(1));
               end
            end
            default: begin
            end
         endcase
      end
   end

   // ---------------------------------------------------------- accept stage
   assign s1_advance     = !out_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !s1_valid_ff || s1_advance;
   assign accept         = req_chan.valid && req_chan.ready;

   assign pix = {req_chan.in_alpha, req_chan.in_blue, req_chan.in_green, req_chan.in_red};

   // Counters left past a shrunken size saturate to the last column or row.
   assign col      = (col_cnt_ff < width_last_ff) ? col_cnt_ff : width_last_ff;
   assign row      = (row_cnt_ff < height_last_ff) ? row_cnt_ff : height_last_ff;
   assign last_col = (col == width_last_ff);
   assign last_row = (row == height_last_ff);
   assign done     = last_col && last_row;
   assign col_odd  = col[0];
   assign row_odd  = row[0];

   always_comb begin
      emit = 1'b0;
      mode = SUM_PIX;
      if (!row_odd) begin
         // Even row: only an odd bottom row closes blocks here.
         if (last_row && col_odd) begin
            emit = 1'b1;
            mode = SUM_HELD_PIX;
         end else if (last_row && last_col) begin
            emit = 1'b1;
            mode = SUM_PIX;
         end
      end else if (!col_odd) begin
         if (last_col) begin
            emit = 1'b1;
            mode = SUM_LINE_PIX;
         end
      end else begin
         emit = 1'b1;
         mode = SUM_FOUR;
      end
   end

   always_comb begin
      col_cnt_in = col_cnt_ff;
      row_cnt_in = row_cnt_ff;
      if (accept) begin
         if (done) begin
            col_cnt_in = '0;
            row_cnt_in = '0;
         end else if (last_col) begin
            col_cnt_in = '0;
            row_cnt_in = row + ROW_W'(1);
         end else begin
            col_cnt_in = col + COL_W'(1);
            row_cnt_in = row;
         end
      end
   end

   // Line buffer: even rows write, odd rows read. A pixel pair shares one
   // address, so a full block reads both halves at once.
   mipbox_ram #(
      .WIDTH (PIX_W),
      .DEPTH (HALF_DEPTH)
   ) u_line_even (
      .clock   (clock),
      .wr_en   (accept && !row_odd && !col_odd),
      .wr_addr (col[COL_W-1:1]),
      .wr_data (pix),
      .rd_en   (accept && row_odd),
      .rd_addr (col[COL_W-1:1]),
      .rd_data (even_rd)
   );

   mipbox_ram #(
      .WIDTH (PIX_W),
      .DEPTH (HALF_DEPTH)
   ) u_line_odd (
      .clock   (clock),
      .wr_en   (accept && !row_odd && col_odd),
      .wr_addr (col[COL_W-1:1]),
      .wr_data (pix),
      .rd_en   (accept && row_odd),
      .rd_addr (col[COL_W-1:1]),
      .rd_data (odd_rd)
   );

   // Read data stays put until the next accept, which only happens once the
   // read stage moves on.
   assign s1_valid_in = (accept && emit) ? 1'b1 : (s1_advance ? 1'b0 : s1_valid_ff);

   // ------------------------------------------------------------ sum stage
   always_comb begin
      logic [SUM_W-1:0] lane_sum;
      for (int k = 0; k < 4; k++) begin
         lane_sum = SUM_W'(s1_pix_ff[k*CHAN_W +: CHAN_W]);
         if (s1_mode_ff == SUM_HELD_PIX || s1_mode_ff == SUM_FOUR) begin
            lane_sum = lane_sum + SUM_W'(s1_held_ff[k*CHAN_W +: CHAN_W]);
         end
         if (s1_mode_ff == SUM_LINE_PIX || s1_mode_ff == SUM_FOUR) begin
            lane_sum = lane_sum + SUM_W'(even_rd[k*CHAN_W +: CHAN_W]);
         end
         if (s1_mode_ff == SUM_FOUR) begin
            lane_sum = lane_sum + SUM_W'(odd_rd[k*CHAN_W +: CHAN_W]);
         end
         // Quarter scale, truncated.
         out_pix_in[k*CHAN_W +: CHAN_W] = lane_sum[SUM_W-1:2];
      end
   end

   assign out_valid_in = (s1_valid_ff && s1_advance) ? 1'b1
                       : (rsp_chan.ready ? 1'b0 : out_valid_ff);

   // ------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_last_ff  <= COL_W'(MAX_WIDTH - 1);
         height_last_ff <= ROW_W'(HEIGHT_LIMIT - 1);
         col_cnt_ff     <= '0;
         row_cnt_ff     <= '0;
         held_ff        <= '0;
         s1_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         width_last_ff  <= width_last_in;
         height_last_ff <= height_last_in;
         col_cnt_ff     <= col_cnt_in;
         row_cnt_ff     <= row_cnt_in;
         if (accept && !col_odd) begin
            held_ff <= pix;
         end
         s1_valid_ff    <= s1_valid_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) begin
         s1_mode_ff <= mode;
         s1_pix_ff  <= pix;
         s1_held_ff <= held_ff;
         s1_col_ff  <= COORD_W'(col >> 1);
         s1_row_ff  <= COORD_W'(row >> 1);
         s1_done_ff <= done;
      end
      if (s1_valid_ff && s1_advance) begin
         out_pix_ff  <= out_pix_in;
         out_col_ff  <= s1_col_ff;
         out_row_ff  <= s1_row_ff;
         out_done_ff <= s1_done_ff;
      end
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.out_red    = out_pix_ff[0*CHAN_W +: CHAN_W];
   assign rsp_chan.out_green  = out_pix_ff[1*CHAN_W +: CHAN_W];
   assign rsp_chan.out_blue   = out_pix_ff[2*CHAN_W +: CHAN_W];
   assign rsp_chan.out_alpha  = out_pix_ff[3*CHAN_W +: CHAN_W];
   assign rsp_chan.out_column = out_col_ff;
   assign rsp_chan.out_row    = out_row_ff;
   assign rsp_chan.frame_done = out_done_ff;

endmodule

/* hw/rtl/mipbox_checker.sv */
// Port-level checks of the downscaler, bound to the top level.
module mipbox_checker
   import mipbox_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_frame_done
);

   // A waiting word stays until taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word dropped while stalled");

   // Reset empties the output register.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word present after reset");

   // Input backpressure only comes from a stalled output.
   a_ready_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled without output backpressure");

   // A fresh result needs a matching pixel accepted earlier and passed through the read stage.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("result word without a matching pixel");

   // A stalled word keeps its end-of-level flag.
   a_done_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_frame_done))
      else $error("frame end flag changed while stalled");

endmodule

bind mipmap_box_2x2_downscale_top mipbox_checker u_mipbox_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_frame_done (rsp_chan.frame_done)
);

/* bench/mipbox_scoreboard_pkg.sv */
// Pixel and result word types plus the scoreboard for the 2x2 box downscaler bench.
`timescale 1ns / 100ps
package mipbox_scoreboard_pkg;
   import mipbox_pkg::*;

   // Packed so that the 64-bit value is red | green<<16 | blue<<32 | alpha<<48.
   typedef struct packed {
      logic [CHAN_W-1:0] alpha;
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] red;
   } rgba_type;

   typedef struct packed {
      rgba_type           color;
      logic [COORD_W-1:0] column;
      logic [COORD_W-1:0] row;
      logic               frame_done;
   } mip_word_type;

   class mip_downscale_scoreboard;
      logic [PIX_W-1:0] line_mem [MAX_WIDTH];
      logic [PIX_W-1:0] held;
      int unsigned      col_cnt;
      int unsigned      row_cnt;
      logic [CFG_W-1:0] width_reg;
      logic [CFG_W-1:0] height_reg;
      mip_word_type     expected_q [$];
      int unsigned      pixels_in;
      int unsigned      words_out;
      int unsigned      levels_done;
      int unsigned      mismatches;

      function new();
         foreach (line_mem[i]) line_mem[i] = '0;
         held        = '0;
         col_cnt     = 0;
         row_cnt     = 0;
         width_reg   = CFG_W'(MAX_WIDTH);
         height_reg  = CFG_W'(HEIGHT_LIMIT);
         pixels_in   = 0;
         words_out   = 0;
         levels_done = 0;
         mismatches  = 0;
      endfunction

      function void write_reg(csr_index_type idx, logic [CFG_W-1:0] value);
         case (idx)
            CSR_IMAGE_WIDTH:  width_reg = value;
            CSR_IMAGE_HEIGHT: height_reg = value;
            default: ;
         endcase
      endfunction

      // Zero reads as one, oversize saturates.
      function int unsigned clamp_dim(logic [CFG_W-1:0] v, int unsigned limit);
         if (v == 0) return 1;
         if (v > limit) return limit;
         return v;
      endfunction

      function void push_block(logic [PIX_W-1:0] blk [4], int n, int unsigned c,
                               int unsigned r, bit done);
         mip_word_type     w;
         rgba_type         p;
         logic [SUM_W-1:0] sum_r;
         logic [SUM_W-1:0] sum_g;
         logic [SUM_W-1:0] sum_b;
         logic [SUM_W-1:0] sum_a;
         sum_r = '0;
         sum_g = '0;
         sum_b = '0;
         sum_a = '0;
         for (int i = 0; i < n; i++) begin
            p = blk[i];
            sum_r += p.red;
            sum_g += p.green;
            sum_b += p.blue;
            sum_a += p.alpha;
         end
         w.color.red   = sum_r[SUM_W-1:2];
         w.color.green = sum_g[SUM_W-1:2];
         w.color.blue  = sum_b[SUM_W-1:2];
         w.color.alpha = sum_a[SUM_W-1:2];
         w.column      = COORD_W'(c >> 1);
         w.row         = COORD_W'(r >> 1);
         w.frame_done  = done;
         expected_q.push_back(w);
      endfunction

      function void note_pixel(rgba_type px);
         int unsigned      w;
         int unsigned      h;
         int unsigned      c;
         int unsigned      r;
         bit               last_col;
         bit               last_row;
         bit               done;
         bit               c_odd;
         logic [PIX_W-1:0] blk [4];
         w        = clamp_dim(width_reg, MAX_WIDTH);
         h        = clamp_dim(height_reg, HEIGHT_LIMIT);
         c        = (col_cnt < w - 1) ? col_cnt : w - 1;
         r        = (row_cnt < h - 1) ? row_cnt : h - 1;
         last_col = (c == w - 1);
         last_row = (r == h - 1);
         done     = last_col && last_row;
         c_odd    = (c % 2) != 0;
         pixels_in++;
         if (r % 2 == 0) begin
            // even row: only a bottom row of odd height closes blocks here
            if (last_row) begin
               if (c_odd) begin
                  blk[0] = held;
                  blk[1] = px;
                  push_block(blk, 2, c, r, done);
               end else if (last_col) begin
                  blk[0] = px;
                  push_block(blk, 1, c, r, done);
               end
            end
            line_mem[c] = px;
            if (!c_odd) held = px;
         end else begin
            if (!c_odd) begin
               held = px;
               if (last_col) begin
                  blk[0] = line_mem[c];
                  blk[1] = px;
                  push_block(blk, 2, c, r, done);
               end
            end else begin
               blk[0] = line_mem[c-1];
               blk[1] = line_mem[c];
               blk[2] = held;
               blk[3] = px;
               push_block(blk, 4, c, r, done);
            end
         end
         if (done) begin
            col_cnt = 0;
            row_cnt = 0;
         end else if (last_col) begin
            col_cnt = 0;
            row_cnt = r + 1;
         end else begin
            col_cnt = c + 1;
            row_cnt = r;
         end
      endfunction

      function void check_result(mip_word_type got);
         mip_word_type want;
         bit           bad;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: unexpected word rgba=%h col=%0d row=%0d done=%b",
                        $time, got.color, got.column, got.row, got.frame_done);
            return;
         end
         want = expected_q.pop_front();
         words_out++;
         if (want.frame_done) levels_done++;
         bad = (got.color.red !== want.color.red) || (got.color.green !== want.color.green)
            || (got.color.blue !== want.color.blue) || (got.color.alpha !== want.color.alpha)
            || (got.column !== want.column) || (got.row !== want.row)
            || (got.frame_done !== want.frame_done);
         if (bad) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("%0t: word mismatch", $time);
               $display("   expected rgba=%h col=%0d row=%0d done=%b",
                        want.color, want.column, want.row, want.frame_done);
               $display("   actual   rgba=%h col=%0d row=%0d done=%b",
                        got.color, got.column, got.row, got.frame_done);
            end
         end
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction

      // Pixels still owed before the current level closes, with counters saturated.
      function int unsigned pixels_to_frame_end();
         int unsigned w;
         int unsigned h;
         int unsigned c;
         int unsigned r;
         w = clamp_dim(width_reg, MAX_WIDTH);
         h = clamp_dim(height_reg, HEIGHT_LIMIT);
         c = (col_cnt < w - 1) ? col_cnt : w - 1;
         r = (row_cnt < h - 1) ? row_cnt : h - 1;
         return (h - 1 - r) * w + (w - c);
      endfunction
   endclass

endpackage

/* bench/tb_mipmap_box_2x2_downscale_top.sv */
// Top-level bench: drives source pixels and size writes, checks every next-level word.
`timescale 1ns / 100ps
module tb_mipmap_box_2x2_downscale_top;
   import mipbox_pkg::*;
   import mipbox_scoreboard_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;  // cycles with no word moving on any channel
   localparam int DRAIN_CYCLES   = 8;     // settling margin for the read stage and output register
   localparam int RANDOM_PIXELS  = 650;

   // Corner channel values walked through by the directed level.
   localparam logic [6*CHAN_W-1:0] CORNERS =
      {16'h8000, 16'h0001, 16'h5555, 16'hAAAA, 16'h0000, 16'hFFFF};

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   logic clock;
   logic reset;
   int   src_idle_pct   = 0;
   int   sink_stall_pct = 0;
   int   idle_cycles    = 0;

   mip_downscale_scoreboard sb;

   mipbox_pix_if req_if ();
   mipbox_out_if rsp_if ();
   mipbox_csr_if csr_if ();

   mipmap_box_2x2_downscale_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Receiver side: stall at random per the current idle mix.
   always @(negedge clock) begin
      rsp_if.ready <= (sink_stall_pct == 0) || ($urandom_range(99) >= sink_stall_pct);
   end

   // Check every accepted result word against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
         sb.check_result({rsp_if.out_alpha, rsp_if.out_blue, rsp_if.out_green,
                          rsp_if.out_red, rsp_if.out_column, rsp_if.out_row,
                          rsp_if.frame_done});
   end

   // Watchdog: end the run if no word moves on any channel for too long.
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
          || (csr_if.valid && csr_if.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
            $display("status: fail");
            $finish;
         end
      end
   end

   task automatic set_idle(idle_mode_type mode);
      case (mode)
         IDLE_NONE:     begin src_idle_pct = 0;  sink_stall_pct = 0;  end
         IDLE_SENDER:   begin src_idle_pct = 71; sink_stall_pct = 0;  end
         IDLE_RECEIVER: begin src_idle_pct = 0;  sink_stall_pct = 71; end
         IDLE_BOTH:     begin src_idle_pct = 23; sink_stall_pct = 23; end
         default: ;
      endcase
   endtask

   // Enter and leave at a falling edge; hold valid across back-to-back words.
   task automatic send_pixel(rgba_type px);
      while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid    <= 1'b1;
      req_if.in_red   <= px.red;
      req_if.in_green <= px.green;
      req_if.in_blue  <= px.blue;
      req_if.in_alpha <= px.alpha;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      sb.note_pixel(px);
      @(negedge clock);
   endtask

   task automatic send_random(int unsigned n);
      rgba_type px;
      repeat (n) begin
         px = {$urandom(), $urandom()};
         send_pixel(px);
      end
   endtask

   task automatic send_rest_of_level();
      send_random(sb.pixels_to_frame_end());
   endtask

   task automatic write_csr(csr_index_type idx, logic [CFG_W-1:0] value);
      @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= value;
      do @(posedge clock); while (csr_if.ready !== 1'b1);
      sb.write_reg(idx, value);
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   task automatic set_size(int w, int h);
      write_csr(CSR_IMAGE_WIDTH, CFG_W'(w));
      write_csr(CSR_IMAGE_HEIGHT, CFG_W'(h));
   endtask

   // Drop valid, wait out every expected word, then let the pipeline settle
   // in case the last pixel closed no block.
   task automatic drain();
      req_if.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   initial begin
      int unsigned start_pixels;
      int unsigned total;
      int          frame_idx;
      int          w;
      int          h;
      rgba_type    px;

      sb              = new();
      reset           = 1'b1;
      req_if.valid    = 1'b0;
      req_if.in_red   = '0;
      req_if.in_green = '0;
      req_if.in_blue  = '0;
      req_if.in_alpha = '0;
      csr_if.valid    = 1'b0;
      csr_if.index    = CSR_IMAGE_WIDTH;
      csr_if.data     = '0;
      rsp_if.ready    = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: full-scale and zero blocks, then a 3x3 level so that the
      // odd right column, odd bottom row and lone corner pixel all appear.
      set_idle(IDLE_NONE);
      set_size(2, 2);
      repeat (4) send_pixel('1);
      repeat (4) send_pixel('0);
      drain();
      set_size(3, 3);
      for (int k = 0; k < 9; k++) begin
         px.red   = CORNERS[(k % 6) * CHAN_W +: CHAN_W];
         px.green = CORNERS[((k + 1) % 6) * CHAN_W +: CHAN_W];
         px.blue  = CORNERS[((k + 2) % 6) * CHAN_W +: CHAN_W];
         px.alpha = CORNERS[((k + 3) % 6) * CHAN_W +: CHAN_W];
         send_pixel(px);
      end
      drain();
      // Zero sizes read as a 1x1 level: one pixel, quartered.
      set_size(0, 0);
      send_pixel('1);
      drain();

      // Oversize registers saturate; shrink mid-level so the counters clamp.
      set_idle(IDLE_SENDER);
      set_size(8191, 5000);
      send_random(6);
      drain();
      set_size(4, 3);
      send_rest_of_level();
      drain();

      // Shrink while part way into an odd row.
      set_idle(IDLE_RECEIVER);
      set_size(6, 4);
      send_random(9);
      drain();
      set_size(2, 2);
      send_rest_of_level();
      drain();

      // Random levels, mostly small, rotating through the idle mixes; some
      // stop part way and shrink before finishing.
      start_pixels = sb.pixels_in;
      frame_idx    = 0;
      while (sb.pixels_in - start_pixels < RANDOM_PIXELS) begin
         set_idle(idle_mode_type'(frame_idx % 4));
         w = ($urandom_range(9) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
         h = ($urandom_range(9) == 0) ? $urandom_range(13, 24) : $urandom_range(1, 10);
         set_size(w, h);
         total = sb.pixels_to_frame_end();
         if ($urandom_range(4) == 0 && total > 1) begin
            send_random($urandom_range(1, total - 1));
            drain();
            set_size($urandom_range(1, w), $urandom_range(1, h));
         end
         send_rest_of_level();
         drain();
         frame_idx++;
      end

      $display("covered %0d source pixels, %0d next-level words, %0d complete levels",
               sb.pixels_in, sb.words_out, sb.levels_done);
      $display("sizes from 1x1 up to 64x24, oversize and zero sizes, mid-level shrinks");
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
